[hw/rtl/vvtp_pkg.sv]
package vvtp_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int TRIG_BITS = 18;

   localparam int COEF_W = TRIG_BITS + 2;
   localparam int PROD_W = COEF_W + 32;
   localparam int SUM_W = PROD_W + 2;
   localparam int CRD_W = SUM_W - TRIG_BITS + 2;
   localparam int T_W = CRD_W + 2;
   localparam int MP_W = T_W + 14;
   localparam int NUM_W = MP_W + 2;
   localparam int DIV_W = NUM_W + 2;
   localparam int Q_W = 16;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);

   localparam logic signed [CRD_W-1:0] NEG_LIMIT =
      CRD_W'(-(((1 << COORD_FRAC_BITS) + 50) / 100));
   localparam logic signed [SUM_W-1:0] SUM_RND = SUM_W'(1 << (TRIG_BITS - 1));
   localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1 << TRIG_BITS);

   localparam logic [31:0] POLY_C1 = 32'd1686629713;
   localparam logic [31:0] POLY_C3 = 32'd693598669;
   localparam logic [31:0] POLY_C5 = 32'd85569307;
   localparam logic [31:0] POLY_C7 = 32'd5026995;
   localparam logic [31:0] POLY_C9 = 32'd172273;

   localparam logic signed [15:0] SCREEN_MAX = 16'sh7FFF;
   localparam logic signed [15:0] SCREEN_MIN = 16'sh8000;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type coef_set_type [8];

   typedef enum logic [2:0] {
      REG_YAW    = 3'd0,
      REG_PITCH  = 3'd1,
      REG_ZOOM   = 3'd2,
      REG_WIDTH  = 3'd3,
      REG_HEIGHT = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_LOAD,
      CS_SINE_MUL,
      CS_SINE_ACC,
      CS_CROSS_MUL,
      CS_CROSS_ACC
   } coef_state_type;

   typedef struct packed {
      logic                    visible;
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [NUM_W-1:0] den;
   } work_type;

   function automatic logic [31:0] poly_coef(input logic [2:0] step);
      logic [31:0] c;
      case (step)
         3'd1: c = POLY_C7;
         3'd2: c = POLY_C5;
         3'd3: c = POLY_C3;
         3'd4: c = POLY_C1;
         default: c = POLY_C9;
      endcase
      return c;
   endfunction

endpackage

[hw/rtl/vvtp_coef.sv]
module vvtp_coef (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output logic                  busy,
   output vvtp_pkg::coef_set_type coef
);
   import vvtp_pkg::*;

   localparam logic [2:0] LAST_STEP = 3'd5;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;
   localparam logic [31:0] TRIG_RND = 32'(1 << (29 - TRIG_BITS));
   localparam logic signed [65:0] CROSS_RND = 66'(1 << (TRIG_BITS - 1));

   coef_state_type state_ff, state_in;
   logic [15:0] yaw_ff;
   logic [14:0] pitch_ff;
   logic [1:0]  idx_ff;
   logic [2:0]  step_ff;
   logic [30:0] t_ff;
   logic [31:0] t2_ff;
   logic [31:0] h_ff;
   logic        neg_ff;
   logic signed [65:0] prod_ff;
   coef_type    sine_ff [4];
   coef_set_type coef_ff;

   logic        start;
   logic [15:0] pitch_ext;
   logic [15:0] angle;
   logic [14:0] arg;
   logic signed [32:0] op_a;
   logic signed [32:0] op_b;
   logic [31:0] p_hi;
   logic [31:0] v_clamp;
   logic [31:0] m_round;
   coef_type    sine_mag;
   coef_type    sine_new;
   logic signed [65:0] cross_wide;
   coef_type    cross_new;

   assign start = csr_we && (csr_index == REG_YAW || csr_index == REG_PITCH);
   assign busy = (state_ff != CS_IDLE);
   assign coef = coef_ff;

   always_comb begin
      pitch_ext = {pitch_ff[14], pitch_ff};
      case (idx_ff)
         2'd0: angle = yaw_ff;
         2'd1: angle = yaw_ff + 16'd16384;
         2'd2: angle = pitch_ext;
         default: angle = pitch_ext + 16'd16384;
      endcase
      arg = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
      if (state_ff == CS_CROSS_MUL) begin
         op_a = 33'(sine_ff[{1'b1, idx_ff[1]}]);
         op_b = 33'(sine_ff[{1'b0, idx_ff[0]}]);
      end else begin
         case (step_ff)
            3'd0: begin
               op_a = $signed({2'b00, t_ff});
               op_b = $signed({2'b00, t_ff});
            end
            LAST_STEP: begin
               op_a = $signed({2'b00, t_ff});
               op_b = $signed({1'b0, h_ff});
            end
            default: begin
               op_a = $signed({1'b0, t2_ff});
               op_b = $signed({1'b0, h_ff});
            end
         endcase
      end
      p_hi = prod_ff[61:30];
      v_clamp = (p_hi > Q30_ONE) ? Q30_ONE : p_hi;
      m_round = (v_clamp + TRIG_RND) >> (30 - TRIG_BITS);
      sine_mag = COEF_W'(m_round);
      sine_new = neg_ff ? -sine_mag : sine_mag;
      cross_wide = (prod_ff + CROSS_RND) >>> TRIG_BITS;
      cross_new = COEF_W'(cross_wide);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: state_in = CS_IDLE;
         CS_LOAD: state_in = CS_SINE_MUL;
         CS_SINE_MUL: state_in = CS_SINE_ACC;
         CS_SINE_ACC: begin
            if (step_ff != LAST_STEP) begin
               state_in = CS_SINE_MUL;
            end else if (idx_ff == 2'd3) begin
               state_in = CS_CROSS_MUL;
            end else begin
               state_in = CS_LOAD;
            end
         end
         CS_CROSS_MUL: state_in = CS_CROSS_ACC;
         CS_CROSS_ACC: state_in = (idx_ff == 2'd3) ? CS_IDLE : CS_CROSS_MUL;
         default: state_in = CS_IDLE;
      endcase
      if (start) begin
         state_in = CS_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         yaw_ff <= '0;
         pitch_ff <= '0;
         idx_ff <= '0;
         step_ff <= '0;
         coef_ff[0] <= COEF_ONE;
         coef_ff[1] <= '0;
         coef_ff[2] <= '0;
         coef_ff[3] <= COEF_ONE;
         coef_ff[4] <= '0;
         coef_ff[5] <= '0;
         coef_ff[6] <= '0;
         coef_ff[7] <= COEF_ONE;
      end else begin
         state_ff <= state_in;
         if (csr_we && csr_index == REG_YAW) begin
            yaw_ff <= csr_wdata[15:0];
         end
         if (csr_we && csr_index == REG_PITCH) begin
            pitch_ff <= csr_wdata[14:0];
         end
         if (start) begin
            idx_ff <= '0;
         end else if (state_ff == CS_SINE_ACC && step_ff == LAST_STEP) begin
            idx_ff <= idx_ff + 2'd1;
         end else if (state_ff == CS_CROSS_ACC) begin
            idx_ff <= idx_ff + 2'd1;
         end
         if (state_ff == CS_LOAD) begin
            step_ff <= '0;
         end else if (state_ff == CS_SINE_ACC && step_ff != LAST_STEP) begin
            step_ff <= step_ff + 3'd1;
         end
         if (state_ff == CS_CROSS_ACC && !start) begin
            case (idx_ff)
               2'd0: coef_ff[2] <= cross_new;
               2'd1: coef_ff[4] <= cross_new;
               2'd2: coef_ff[5] <= cross_new;
               default: begin
                  coef_ff[7] <= cross_new;
                  coef_ff[0] <= sine_ff[1];
                  coef_ff[1] <= -sine_ff[0];
                  coef_ff[3] <= sine_ff[3];
                  coef_ff[6] <= -sine_ff[2];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == CS_LOAD) begin
         t_ff <= {arg, 16'd0};
         neg_ff <= angle[15];
      end
      if (state_ff == CS_SINE_MUL || state_ff == CS_CROSS_MUL) begin
         prod_ff <= op_a * op_b;
      end
      if (state_ff == CS_SINE_ACC) begin
         case (step_ff)
            3'd0: begin
               t2_ff <= p_hi;
               h_ff <= poly_coef(step_ff);
            end
            LAST_STEP: sine_ff[idx_ff] <= sine_new;
            default: h_ff <= poly_coef(step_ff) - p_hi;
         endcase
      end
   end

endmodule

[hw/rtl/vvtp_front.sv]
module vvtp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_vertex_x,
   input  logic signed [31:0]     req_vertex_y,
   input  logic signed [31:0]     req_vertex_z,
   input  vvtp_pkg::coef_set_type coef,
   input  logic                   coef_busy,
   input  logic [31:0]            zoom,
   input  logic [12:0]            width,
   input  logic [12:0]            height,
   input  logic                   queue_full,
   output logic                   push,
   output vvtp_pkg::work_type     push_data
);
   import vvtp_pkg::*;

   logic [4:0] v_ff;
   logic       front_en;
   logic       accept;

   logic signed [PROD_W-1:0] prod_ff [8];
   logic signed [CRD_W-1:0]  xr_ff, yr_ff, zr_ff;
   logic signed [T_W-1:0]    tx_ff, ty_ff;
   logic signed [CRD_W-1:0]  z3_ff, z4_ff;
   logic                     vis3_ff, vis4_ff, vis5_ff;
   logic signed [MP_W-1:0]   mx_ff, my_ff;
   logic signed [NUM_W-1:0]  nx_ff, ny_ff, d_ff;

   logic signed [SUM_W-1:0]  sx, sy, sz;
   logic signed [CRD_W-1:0]  xr_in, yr_in, zr_in;

   assign front_en = !v_ff[4] || !queue_full;
   assign req_ready = front_en && !coef_busy;
   assign accept = req_valid && req_ready;
   assign push = v_ff[4] && !queue_full;
   assign push_data = '{visible: vis5_ff, num_x: nx_ff, num_y: ny_ff, den: d_ff};

   always_comb begin
      sx = SUM_W'(prod_ff[0]) + SUM_W'(prod_ff[1]) + SUM_RND;
      sy = SUM_W'(prod_ff[2]) + SUM_W'(prod_ff[3]) + SUM_W'(prod_ff[4]) + SUM_RND;
      sz = SUM_W'(prod_ff[5]) + SUM_W'(prod_ff[6]) + SUM_W'(prod_ff[7]) + SUM_RND;
      xr_in = CRD_W'(sx >>> TRIG_BITS);
      yr_in = CRD_W'(sy >>> TRIG_BITS);
      zr_in = CRD_W'(sz >>> TRIG_BITS) - CRD_W'($signed({1'b0, zoom}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (front_en) begin
         v_ff <= {v_ff[3:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      if (front_en) begin
         prod_ff[0] <= PROD_W'(coef[0]) * PROD_W'(req_vertex_x);
         prod_ff[1] <= PROD_W'(coef[1]) * PROD_W'(req_vertex_z);
         prod_ff[2] <= PROD_W'(coef[2]) * PROD_W'(req_vertex_x);
         prod_ff[3] <= PROD_W'(coef[3]) * PROD_W'(req_vertex_y);
         prod_ff[4] <= PROD_W'(coef[4]) * PROD_W'(req_vertex_z);
         prod_ff[5] <= PROD_W'(coef[5]) * PROD_W'(req_vertex_x);
         prod_ff[6] <= PROD_W'(coef[6]) * PROD_W'(req_vertex_y);
         prod_ff[7] <= PROD_W'(coef[7]) * PROD_W'(req_vertex_z);

         xr_ff <= xr_in;
         yr_ff <= yr_in;
         zr_ff <= zr_in;

         vis3_ff <= (zr_ff <= NEG_LIMIT);
         tx_ff <= (T_W'(xr_ff) <<< 1) + T_W'(zr_ff);
         ty_ff <= (T_W'(yr_ff) <<< 1) + T_W'(zr_ff);
         z3_ff <= zr_ff;

         vis4_ff <= vis3_ff;
         mx_ff <= MP_W'($signed({1'b0, width})) * MP_W'(tx_ff);
         my_ff <= MP_W'($signed({1'b0, height})) * MP_W'(ty_ff);
         z4_ff <= z3_ff;

         vis5_ff <= vis4_ff;
         nx_ff <= -(NUM_W'(mx_ff) <<< 1) - (NUM_W'(z4_ff) <<< 1);
         ny_ff <= -(NUM_W'(my_ff) <<< 1) - (NUM_W'(z4_ff) <<< 1);
         d_ff <= -(NUM_W'(z4_ff) <<< 2);
      end
   end

endmodule

[hw/rtl/vvtp_queue.sv]
module vvtp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vvtp_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output vvtp_pkg::work_type pop_data,
   output logic               empty
);
   import vvtp_pkg::*;

   work_type           mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   assign full = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/vvtp_back.sv]
module vvtp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   output logic               pop,
   input  vvtp_pkg::work_type pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic               rsp_visible
);
   import vvtp_pkg::*;

   logic [Q_W:0] v_ff;
   logic         out_v_ff;
   logic         back_en;

   logic                    vis_ff [Q_W+1];
   logic                    hix_ff [Q_W+1];
   logic                    lox_ff [Q_W+1];
   logic                    hiy_ff [Q_W+1];
   logic                    loy_ff [Q_W+1];
   logic signed [DIV_W-1:0] d_ff [Q_W+1];
   logic signed [DIV_W-1:0] remx_ff [Q_W+1];
   logic signed [DIV_W-1:0] remy_ff [Q_W+1];
   logic [Q_W-1:0]          qx_ff [Q_W+1];
   logic [Q_W-1:0]          qy_ff [Q_W+1];

   logic signed [15:0] sx_ff, sy_ff;
   logic               svis_ff;

   logic signed [DIV_W-1:0] d0, hi0, nx0, ny0;
   logic signed [DIV_W-1:0] trialx [Q_W+1];
   logic signed [DIV_W-1:0] trialy [Q_W+1];

   assign back_en = !out_v_ff || rsp_ready;
   assign pop = back_en && !queue_empty;
   assign rsp_valid = out_v_ff;
   assign rsp_screen_x = sx_ff;
   assign rsp_screen_y = sy_ff;
   assign rsp_visible = svis_ff;

   always_comb begin
      d0 = DIV_W'(pop_data.den);
      hi0 = d0 <<< (Q_W - 1);
      nx0 = DIV_W'(pop_data.num_x);
      ny0 = DIV_W'(pop_data.num_y);
      trialx[0] = '0;
      trialy[0] = '0;
      for (int j = 1; j <= Q_W; j++) begin
         trialx[j] = remx_ff[j-1] - (d_ff[j-1] <<< (Q_W - j));
         trialy[j] = remy_ff[j-1] - (d_ff[j-1] <<< (Q_W - j));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         out_v_ff <= 1'b0;
      end else if (back_en) begin
         v_ff <= {v_ff[Q_W-1:0], pop};
         out_v_ff <= v_ff[Q_W];
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) begin
         vis_ff[0] <= pop_data.visible;
         d_ff[0] <= d0;
         hix_ff[0] <= (nx0 >= hi0);
         lox_ff[0] <= (nx0 < -hi0);
         hiy_ff[0] <= (ny0 >= hi0);
         loy_ff[0] <= (ny0 < -hi0);
         remx_ff[0] <= nx0 + hi0;
         remy_ff[0] <= ny0 + hi0;
         qx_ff[0] <= '0;
         qy_ff[0] <= '0;
         for (int j = 1; j <= Q_W; j++) begin
            vis_ff[j] <= vis_ff[j-1];
            d_ff[j] <= d_ff[j-1];
            hix_ff[j] <= hix_ff[j-1];
            lox_ff[j] <= lox_ff[j-1];
            hiy_ff[j] <= hiy_ff[j-1];
            loy_ff[j] <= loy_ff[j-1];
            if (!trialx[j][DIV_W-1]) begin
               remx_ff[j] <= trialx[j];
               qx_ff[j] <= qx_ff[j-1] | (Q_W'(1) << (Q_W - j));
            end else begin
               remx_ff[j] <= remx_ff[j-1];
               qx_ff[j] <= qx_ff[j-1];
            end
            if (!trialy[j][DIV_W-1]) begin
               remy_ff[j] <= trialy[j];
               qy_ff[j] <= qy_ff[j-1] | (Q_W'(1) << (Q_W - j));
            end else begin
               remy_ff[j] <= remy_ff[j-1];
               qy_ff[j] <= qy_ff[j-1];
            end
         end

         svis_ff <= vis_ff[Q_W];
         if (!vis_ff[Q_W]) begin
            sx_ff <= '0;
         end else if (hix_ff[Q_W]) begin
            sx_ff <= SCREEN_MAX;
         end else if (lox_ff[Q_W]) begin
            sx_ff <= SCREEN_MIN;
         end else begin
            sx_ff <= {~qx_ff[Q_W][Q_W-1], qx_ff[Q_W][Q_W-2:0]};
         end
         if (!vis_ff[Q_W]) begin
            sy_ff <= '0;
         end else if (hiy_ff[Q_W]) begin
            sy_ff <= SCREEN_MAX;
         end else if (loy_ff[Q_W]) begin
            sy_ff <= SCREEN_MIN;
         end else begin
            sy_ff <= {~qy_ff[Q_W][Q_W-1], qy_ff[Q_W][Q_W-2:0]};
         end
      end
   end

endmodule

[hw/rtl/vertex_view_transform_project_top.sv]
// An accepted word passes the five-stage transform pipeline, a four-word queue between
// it and the sixteen-stage restoring divider, and an output register. Throughput: one
// word per cycle unless held by rsp_ready, a full queue or a coefficient rebuild.
// A yaw or pitch write holds req_ready low while the shared multiplier
// rebuilds the rotation coefficients.
// Reset is synchronous; it restores the register defaults and identity coefficients.
module vertex_view_transform_project_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic               rsp_visible,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import vvtp_pkg::*;

   logic [31:0] zoom_ff;
   logic [12:0] width_ff;
   logic [12:0] height_ff;

   coef_set_type coef;
   logic         coef_busy;
   logic         push, pop, queue_full, queue_empty;
   work_type     push_data, pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= 32'd3276800;
         width_ff <= 13'd800;
         height_ff <= 13'd600;
      end else if (csr_we) begin
         if (csr_index == REG_ZOOM) begin
            zoom_ff <= csr_wdata;
         end
         if (csr_index == REG_WIDTH) begin
            width_ff <= csr_wdata[12:0];
         end
         if (csr_index == REG_HEIGHT) begin
            height_ff <= csr_wdata[12:0];
         end
      end
   end

   vvtp_coef u_coef (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (coef_busy),
      .coef      (coef)
   );

   vvtp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_vertex_x (req_vertex_x),
      .req_vertex_y (req_vertex_y),
      .req_vertex_z (req_vertex_z),
      .coef         (coef),
      .coef_busy    (coef_busy),
      .zoom         (zoom_ff),
      .width        (width_ff),
      .height       (height_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_data    (push_data)
   );

   vvtp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   vvtp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .pop          (pop),
      .pop_data     (pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_screen_x (rsp_screen_x),
      .rsp_screen_y (rsp_screen_y),
      .rsp_visible  (rsp_visible)
   );

endmodule

[hw/rtl/vvtp_checker.sv]
module vvtp_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_screen_x,
   input logic signed [15:0] rsp_screen_y,
   input logic               rsp_visible,
   input logic               csr_we,
   input logic [2:0]         csr_index
);
   import vvtp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_screen_x)
         && $stable(rsp_screen_y) && $stable(rsp_visible))
      else $error("result word changed while stalled");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_screen_x == 16'sd0 && rsp_screen_y == 16'sd0)
      else $error("hidden vertex with nonzero screen position");

   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   a_angle_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we && (csr_index == REG_YAW || csr_index == REG_PITCH) |=> !req_ready)
      else $error("input open while coefficients rebuild");

endmodule

bind vertex_view_transform_project_top vvtp_port_checker u_checker (.*);

[tb/vvtp_checker.sv]
module vvtp_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_vertex_x,
   input  logic signed [31:0] req_vertex_y,
   input  logic signed [31:0] req_vertex_z,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_screen_x,
   input  logic signed [15:0] rsp_screen_y,
   input  logic               rsp_visible,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 pending,
   output int                 failures
);
   timeunit 1ns;
   timeprecision 1ps;
   import vvtp_pkg::*;

   typedef struct {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               visible;
   } screen_point_type;

   screen_point_type expected_points[$];

   logic [15:0] yaw;
   logic [14:0] pitch;
   logic [31:0] zoom;
   logic [12:0] width;
   logic [12:0] height;
   longint      rotation[8];

   function automatic longint round_shift(input longint v, input int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint unsigned quarter_wave(input longint unsigned r);
      longint unsigned t, t2, h;
      t = r << 16;
      t2 = (t * t) >> 30;
      h = POLY_C9;
      h = POLY_C7 - ((t2 * h) >> 30);
      h = POLY_C5 - ((t2 * h) >> 30);
      h = POLY_C3 - ((t2 * h) >> 30);
      h = POLY_C1 - ((t2 * h) >> 30);
      h = (t * h) >> 30;
      return (h > (64'd1 << 30)) ? (64'd1 << 30) : h;
   endfunction

   function automatic longint sine_of(input logic [15:0] a);
      longint unsigned v, m;
      v = a[14] ? quarter_wave(16384 - a[13:0]) : quarter_wave(a[13:0]);
      m = (v + (64'd1 << (29 - TRIG_BITS))) >> (30 - TRIG_BITS);
      return a[15] ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint cosine_of(input logic [15:0] a);
      return sine_of(a + 16'd16384);
   endfunction

   function automatic void rebuild_rotation();
      logic [15:0] pa;
      longint      cy, sy, cp, sp;
      pa = {pitch[14], pitch};
      cy = cosine_of(yaw);
      sy = sine_of(yaw);
      cp = cosine_of(pa);
      sp = sine_of(pa);
      rotation[0] = cy;
      rotation[1] = -sy;
      rotation[2] = round_shift(sp * sy, TRIG_BITS);
      rotation[3] = cp;
      rotation[4] = round_shift(sp * cy, TRIG_BITS);
      rotation[5] = round_shift(cp * sy, TRIG_BITS);
      rotation[6] = -sp;
      rotation[7] = round_shift(cp * cy, TRIG_BITS);
   endfunction

   function automatic logic signed [15:0] to_screen(input longint c, input longint z,
                                                     input longint s);
      longint num, den, n, d, q;
      num = -s * (2 * c + z);
      den = -2 * z;
      n = 2 * num + den;
      d = 2 * den;
      q = n / d;
      if ((n % d) != 0 && n < 0) begin
         q = q - 1;
      end
      if (q > 32767) begin
         q = 32767;
      end
      if (q < -32768) begin
         q = -32768;
      end
      return 16'(q);
   endfunction

   function automatic screen_point_type project_vertex(input longint x, input longint y,
                                                        input longint z);
      screen_point_type p;
      longint xr, yr, zr, limit;
      xr = round_shift(rotation[0] * x + rotation[1] * z, TRIG_BITS);
      yr = round_shift(rotation[2] * x + rotation[3] * y + rotation[4] * z, TRIG_BITS);
      zr = round_shift(rotation[5] * x + rotation[6] * y + rotation[7] * z, TRIG_BITS)
           - longint'(zoom);
      limit = ((longint'(1) << COORD_FRAC_BITS) + 50) / 100;
      if (zr <= -limit) begin
         p.screen_x = to_screen(xr, zr, longint'(width));
         p.screen_y = to_screen(yr, zr, longint'(height));
         p.visible = 1'b1;
      end else begin
         p.screen_x = '0;
         p.screen_y = '0;
         p.visible = 1'b0;
      end
      return p;
   endfunction

   always @(posedge clock) begin
      screen_point_type got;
      screen_point_type want;
      if (reset) begin
         yaw = '0;
         pitch = '0;
         zoom = 32'd3276800;
         width = 13'd800;
         height = 13'd600;
         rebuild_rotation();
         expected_points.delete();
         failures <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_YAW: begin
                  yaw = csr_wdata[15:0];
                  rebuild_rotation();
               end
               REG_PITCH: begin
                  pitch = csr_wdata[14:0];
                  rebuild_rotation();
               end
               REG_ZOOM: zoom = csr_wdata;
               REG_WIDTH: width = csr_wdata[12:0];
               REG_HEIGHT: height = csr_wdata[12:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_points.push_back(project_vertex(req_vertex_x, req_vertex_y,
                                                     req_vertex_z));
         end
         if (rsp_valid && rsp_ready) begin
            got.screen_x = rsp_screen_x;
            got.screen_y = rsp_screen_y;
            got.visible = rsp_visible;
            if (expected_points.size() == 0) begin
               $error("Result word arrived with nothing expected.");
               failures <= failures + 1;
            end else begin
               want = expected_points.pop_front();
               if (got.screen_x !== want.screen_x) begin
                  $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
                  failures <= failures + 1;
               end else if (got.screen_y !== want.screen_y) begin
                  $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
                  failures <= failures + 1;
               end else if (got.visible !== want.visible) begin
                  $error("visible: expected %0d, got %0d", want.visible, got.visible);
                  failures <= failures + 1;
               end
            end
         end
      end
      pending <= expected_points.size();
   end

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vvtp_pkg::*;

   localparam logic [2:0] REG_UNUSED = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [31:0] req_vertex_x;
   logic signed [31:0] req_vertex_y;
   logic signed [31:0] req_vertex_z;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_screen_x;
   logic signed [15:0] rsp_screen_y;
   logic               rsp_visible;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;
   int                 pending;
   int                 failures;
   logic               steady;

   vertex_view_transform_project_top i_dut (.*);

   vvtp_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 28);
   end

   task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                              input logic [31:0] vz);
      while (!steady && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= vx;
      req_vertex_y <= vy;
      req_vertex_z <= vz;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] yaw_v, input logic [31:0] pitch_v,
                                input logic [31:0] zoom_v, input logic [31:0] width_v,
                                input logic [31:0] height_v);
      logic [31:0] values[5];
      values = '{yaw_v, pitch_v, zoom_v, width_v, height_v};
      csr_we <= 1'b1;
      for (int i = 0; i < 5; i++) begin
         csr_index <= 3'(i);
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_index <= REG_UNUSED - 3'($urandom_range(0, 2));
      csr_wdata <= $urandom();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] random_coord();
      if ($urandom_range(99) < 20) begin
         return $urandom();
      end
      return 32'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
   endfunction

   initial begin
      logic [31:0] pitch_v;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_vertex_x <= '0;
      req_vertex_y <= '0;
      req_vertex_z <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_YAW;
      csr_wdata <= '0;
      steady <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_vertex(0, 0, 0);
      send_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
      send_vertex(32'h7FFFFFFF, 32'h80000000, 0);
      send_vertex(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_vertex(0, 0, 32'd3276145);
      send_vertex(0, 0, 32'd3276146);
      send_vertex(32'h40000000, 32'hC0000000, 32'd3276145);
      send_vertex(32'hC0000000, 32'h40000000, 32'd3276145);
      send_vertex(32'h00010000, 32'hFFFF0000, 32'hFF000000);
      send_vertex(32'hFFFF8000, 32'h00008000, 32'h00000000);
      send_vertex(32'h00640000, 32'h00640000, 32'hFF9C0000);
      send_vertex(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_vertex(32'h00000001, 32'h00000001, 32'h00000001);
      for (int i = 0; i < 6; i++) begin
         send_vertex(random_coord(), random_coord(), random_coord());
      end
      drain();

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: load_settings(0, 32'(-10430), 0, 1, 1);
            1: load_settings(65535, 10430, 32'hFFFFFFFF, 4096, 4096);
            2: load_settings(16384, 32'hFFFFC000, 32'd655360, 0, 8191);
            3: load_settings($urandom(), 32'h00003FFF, $urandom_range(0, 150 << 16),
                             8191, 0);
            default: begin
               pitch_v = ($urandom_range(9) == 0) ? $urandom()
                         : 32'(int'($urandom_range(0, 20860)) - 10430);
               load_settings($urandom(), pitch_v, $urandom_range(0, 150 << 16),
                             $urandom_range(1, 4096), $urandom_range(1, 4096));
            end
         endcase
         steady <= (phase == 5);
         for (int i = 0; i < 70; i++) begin
            send_vertex(random_coord(), random_coord(), random_coord());
         end
         drain();
      end

      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/vvtp_pkg.sv
hw/rtl/vvtp_coef.sv
hw/rtl/vvtp_front.sv
hw/rtl/vvtp_queue.sv
hw/rtl/vvtp_back.sv
hw/rtl/vertex_view_transform_project_top.sv
hw/rtl/vvtp_checker.sv
tb/vvtp_checker.sv
tb/tb.sv
